// ===== hw/rtl/qkfs_pkg.sv =====
// qkfs_pkg: shared types, register indexes and constants for the quadrature
// knob frequency setter. No dependencies; imported by every qkfs module.

package qkfs_pkg;

	localparam int FREQ_W    = 24;
	localparam int DISP_W    = 17;
	localparam int DETENT_W  = 3;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQUENCY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQUENCY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_DETENT = 2'd2;

	localparam logic [FREQ_W-1:0]   MIN_FREQ_RESET  = 24'd20;
	localparam logic [FREQ_W-1:0]   MAX_FREQ_RESET  = 24'd10000000;
	localparam logic [DETENT_W-1:0] DETENT_RESET    = 3'd4;
	localparam logic [FREQ_W-1:0]   SETTING_RESET   = 24'd20;
	localparam logic [FREQ_W-1:0]   KHZ_THRESHOLD   = 24'd99999;

	// floor(f / 1000) = (f * KHZ_RECIP) >> KHZ_SHIFT, exact for every 24-bit f
	localparam int                  KHZ_SHIFT = 34;
	localparam logic [24:0]         KHZ_RECIP = 25'd17179870;

	typedef struct packed {
		logic pin_a;
		logic pin_b;
	} in_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency;
		logic              changed;
		logic [DISP_W-1:0] display_number;
		logic              display_khz;
	} out_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0]   min_frequency;
		logic [FREQ_W-1:0]   max_frequency;
		logic [DETENT_W-1:0] counts_per_detent;
	} cfg_t;

	// knob step size for the decade the setting is in
	function automatic logic [16:0] step_size(input logic [FREQ_W-1:0] f);
		logic [16:0] s;
		if (f < 24'd100)          s = 17'd1;
		else if (f < 24'd1000)    s = 17'd10;
		else if (f < 24'd10000)   s = 17'd100;
		else if (f < 24'd100000)  s = 17'd1000;
		else if (f < 24'd1000000) s = 17'd10000;
		else                      s = 17'd100000;
		return s;
	endfunction

endpackage

// ===== hw/rtl/qkfs_knob.sv =====
// qkfs_knob: x4 quadrature edge counting, detent detection and clamped
// frequency stepping; holds the knob state. Depends on qkfs_pkg.

module qkfs_knob (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  qkfs_pkg::in_item_t            item,
	input  qkfs_pkg::cfg_t                cfg,
	output logic [qkfs_pkg::FREQ_W-1:0]   freq_s1,
	output logic                          changed_s1
);
	import qkfs_pkg::*;

	logic [1:0]              prev_q;
	logic signed [3:0]       count_q;
	logic [FREQ_W-1:0]       setting_q;
	logic [FREQ_W-1:0]       last_q;

	logic [1:0]              lvl;
	logic [1:0]              rise;
	logic [1:0]              fall;
	logic signed [2:0]       delta;
	logic signed [4:0]       count_sum;
	logic signed [4:0]       count_sat;
	logic signed [4:0]       thr;
	logic                    step_up;
	logic                    step_down;
	logic signed [25:0]      sum;
	logic signed [25:0]      step;
	logic [FREQ_W-1:0]       setting_next;
	logic [3:0]              count_next;

	assign lvl  = {item.pin_b, item.pin_a};
	assign rise = ~prev_q & lvl;
	assign fall = prev_q & ~lvl;

	always_comb begin
		delta = 3'sd0;
		if (rise[0]) delta = delta + (lvl[1] ? -3'sd1 : 3'sd1);
		if (fall[0]) delta = delta + (lvl[1] ? 3'sd1 : -3'sd1);
		if (rise[1]) delta = delta + (lvl[0] ? 3'sd1 : -3'sd1);
		if (fall[1]) delta = delta + (lvl[0] ? -3'sd1 : 3'sd1);
	end

	assign count_sum = {count_q[3], count_q} + {{2{delta[2]}}, delta};

	always_comb begin
		if (count_sum > 5'sd7)       count_sat = 5'sd7;
		else if (count_sum < -5'sd8) count_sat = -5'sd8;
		else                         count_sat = count_sum;
	end

	// a zero detent size counts as one
	assign thr = (cfg.counts_per_detent == '0) ? 5'sd1 :
		$signed({2'b00, cfg.counts_per_detent});
	assign step_up   = count_sat >= thr;
	assign step_down = !step_up && (count_sat <= -thr);

	assign count_next = (step_up || step_down) ? 4'd0 : count_sat[3:0];

	assign step = $signed({9'd0, step_size(setting_q)});
	assign sum  = $signed({2'b00, setting_q}) + (step_up ? step : -step);

	// minimum is tested before maximum
	always_comb begin
		if (!(step_up || step_down))
			setting_next = setting_q;
		else if (sum < $signed({2'b00, cfg.min_frequency}))
			setting_next = cfg.min_frequency;
		else if (sum > $signed({2'b00, cfg.max_frequency}))
			setting_next = cfg.max_frequency;
		else
			setting_next = sum[FREQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			count_q   <= '0;
			setting_q <= SETTING_RESET;
			last_q    <= '0;
		end else if (take) begin
			prev_q    <= lvl;
			count_q   <= count_next;
			setting_q <= setting_next;
			last_q    <= setting_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			freq_s1    <= setting_next;
			changed_s1 <= last_q != setting_next;
		end
	end

endmodule

// ===== hw/rtl/qkfs_display.sv =====
// qkfs_display: output stage forming the display number (hertz or kilohertz)
// and holding the result register. Depends on qkfs_pkg.

module qkfs_display (
	input  logic                          clk,
	input  logic                          load,
	input  logic [qkfs_pkg::FREQ_W-1:0]   freq_s1,
	input  logic                          changed_s1,
	output qkfs_pkg::out_item_t           result_q
);
	import qkfs_pkg::*;

	logic [48:0]       prod;
	logic [14:0]       khz_value;
	logic              is_khz;

	assign prod      = {25'd0, freq_s1} * {24'd0, KHZ_RECIP};
	assign khz_value = prod[KHZ_SHIFT +: 15];
	assign is_khz    = freq_s1 > KHZ_THRESHOLD;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.frequency      <= freq_s1;
			result_q.changed        <= changed_s1;
			result_q.display_number <= is_khz ? {2'b00, khz_value} : freq_s1[DISP_W-1:0];
			result_q.display_khz    <= is_khz;
		end
	end

endmodule

// ===== hw/rtl/quadrature_knob_frequency_setter.sv =====
// quadrature_knob_frequency_setter: top level with configuration registers
// and pipeline handshake. Depends on qkfs_pkg, qkfs_knob and qkfs_display.

// The block takes one sampled pair of encoder levels per transaction and
// returns exactly one result transaction for it: the frequency setting, a
// changed flag and a display number with a kilohertz flag. It accepts a new
// transaction every clock cycle while in_ready is high; a result passes from the
// knob update stage to the display stage with the divide-by-1000 reciprocal
// multiply, and out_valid rises when the display stage loads. in_ready only
// drops when both stages hold results and the output is stalled.
// Configuration writes take effect at once and are meant to happen while the
// block is idle.

module quadrature_knob_frequency_setter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  qkfs_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output qkfs_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [qkfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qkfs_pkg::FREQ_W-1:0]     cfg_data
);
	import qkfs_pkg::*;

	cfg_t                cfg_q;
	logic                valid_s1;
	logic                out_valid_q;
	logic                take;
	logic                advance;
	logic                out_free;
	logic [FREQ_W-1:0]   freq_s1;
	logic                changed_s1;

	// configuration registers, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_frequency     <= MIN_FREQ_RESET;
			cfg_q.max_frequency     <= MAX_FREQ_RESET;
			cfg_q.counts_per_detent <= DETENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_FREQUENCY:     cfg_q.min_frequency     <= cfg_data;
				REG_MAX_FREQUENCY:     cfg_q.max_frequency     <= cfg_data;
				REG_COUNTS_PER_DETENT: cfg_q.counts_per_detent <= cfg_data[DETENT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control: output register frees when empty or being taken
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)          valid_s1 <= 1'b1;
			else if (advance)  valid_s1 <= 1'b0;
			if (advance)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// knob state update at acceptance
	qkfs_knob u_knob (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (in_data),
		.cfg        (cfg_q),
		.freq_s1    (freq_s1),
		.changed_s1 (changed_s1)
	);

	// display formatting into the result register
	qkfs_display u_display (
		.clk        (clk),
		.load       (advance),
		.freq_s1    (freq_s1),
		.changed_s1 (changed_s1),
		.result_q   (out_data)
	);

	assign out_valid = out_valid_q;

	// back-pressure only when both stages are full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a full stalled pipeline");

	// kilohertz flag agrees with the frequency it describes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.display_khz == (out_data.frequency > KHZ_THRESHOLD)))
		else $error("display_khz inconsistent with frequency");

	// display number always fits five digits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.display_number <= KHZ_THRESHOLD[DISP_W-1:0]))
		else $error("display_number out of range");

	// a result taken while the knob stage is empty leaves the output empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !valid_s1) |=> !out_valid)
		else $error("result repeated after transaction");

endmodule
